/* rtl/thhc_pkg.sv */
// Package: shared types, register indexes and reset values for the torch height control.
package thhc_pkg;

  // Field widths
  localparam int unsigned VoltW   = 10;
  localparam int unsigned HystW   = 8;
  localparam int unsigned TicksW  = 16;
  localparam int unsigned CountW  = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 16;

  // Kerf wait parameter default; the value is truncated to TicksW bits
  localparam int unsigned KerfWaitDefault = 12;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegSetPoint  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegOnHyst    = 3'd1;
  localparam logic [CfgIdxW-1:0] RegOffHyst   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegStabMs    = 3'd3;
  localparam logic [CfgIdxW-1:0] RegJumpLimit = 3'd4;

  // Register reset values
  localparam logic [VoltW-1:0]  SetPointRst  = 10'd512;
  localparam logic [HystW-1:0]  OnHystRst    = 8'd7;
  localparam logic [HystW-1:0]  OffHystRst   = 8'd3;
  localparam logic [TicksW-1:0] StabMsRst    = 16'd500;
  localparam logic [VoltW-1:0]  JumpLimitRst = 10'd21;

  localparam logic [TicksW-1:0] TicksMax = '1;

  typedef struct packed {
    logic [VoltW-1:0]  set_point;
    logic [HystW-1:0]  on_hysteresis;
    logic [HystW-1:0]  off_hysteresis;
    logic [TicksW-1:0] stabilize_ms;
    logic [VoltW-1:0]  kerf_jump_limit;
  } cfg_t;

  typedef struct packed {
    logic [VoltW-1:0] voltage;
    logic             torch_on;
    logic             arc_good;
  } item_t;

  typedef struct packed {
    logic              torch_up;
    logic              torch_down;
    logic              kerf_active;
    logic              control_active;
    logic              pierce_done;
    logic [CountW-1:0] pierce_total;
    logic              leave_cutting;
  } result_t;

endpackage

/* rtl/thhc_if.sv */
// Interfaces: valid/ready channels for tick items and control results.
interface thhc_in_if;
  logic                          valid;
  logic                          ready;
  logic [thhc_pkg::VoltW-1:0]    voltage;
  logic                          torch_on;
  logic                          arc_good;

  modport source (output valid, output voltage, output torch_on, output arc_good, input ready);
  modport sink   (input valid, input voltage, input torch_on, input arc_good, output ready);
endinterface

interface thhc_out_if;
  logic                          valid;
  logic                          ready;
  logic                          torch_up;
  logic                          torch_down;
  logic                          kerf_active;
  logic                          control_active;
  logic                          pierce_done;
  logic [thhc_pkg::CountW-1:0]   pierce_total;
  logic                          leave_cutting;

  modport source (output valid, output torch_up, output torch_down, output kerf_active,
                  output control_active, output pierce_done, output pierce_total,
                  output leave_cutting, input ready);
  modport sink   (input valid, input torch_up, input torch_down, input kerf_active,
                  input control_active, input pierce_done, input pierce_total,
                  input leave_cutting, output ready);
endinterface

/* rtl/thhc_cfg.sv */
// Configuration register file: five write-only setup registers.
module thhc_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [thhc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [thhc_pkg::CfgDatW-1:0]   cfg_data_i,
  output thhc_pkg::cfg_t                 cfg_o
);

  thhc_pkg::cfg_t cfg_q;

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.set_point       <= thhc_pkg::SetPointRst;
      cfg_q.on_hysteresis   <= thhc_pkg::OnHystRst;
      cfg_q.off_hysteresis  <= thhc_pkg::OffHystRst;
      cfg_q.stabilize_ms    <= thhc_pkg::StabMsRst;
      cfg_q.kerf_jump_limit <= thhc_pkg::JumpLimitRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        thhc_pkg::RegSetPoint:  cfg_q.set_point       <= cfg_data_i[thhc_pkg::VoltW-1:0];
        thhc_pkg::RegOnHyst:    cfg_q.on_hysteresis   <= cfg_data_i[thhc_pkg::HystW-1:0];
        thhc_pkg::RegOffHyst:   cfg_q.off_hysteresis  <= cfg_data_i[thhc_pkg::HystW-1:0];
        thhc_pkg::RegStabMs:    cfg_q.stabilize_ms    <= cfg_data_i[thhc_pkg::TicksW-1:0];
        thhc_pkg::RegJumpLimit: cfg_q.kerf_jump_limit <= cfg_data_i[thhc_pkg::VoltW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/thhc_step.sv */
// Control state and per-tick next-state logic: hysteresis drive, kerf detect, pierce count.
module thhc_step #(
  parameter int unsigned KERF_WAIT_MS = thhc_pkg::KerfWaitDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  thhc_pkg::item_t     item_i,
  input  thhc_pkg::cfg_t      cfg_i,
  output thhc_pkg::result_t   res_o
);

  localparam logic [thhc_pkg::TicksW-1:0] KerfWait = thhc_pkg::TicksW'(KERF_WAIT_MS);

  logic                          cutting_q, cutting_d;
  logic                          prev_arc_q;
  logic                          up_q, up_d, down_q, down_d, kerf_q, kerf_d, run_q, run_d;
  logic [thhc_pkg::TicksW-1:0]   stab_q, stab_d, kt_q, kt_d;
  logic [thhc_pkg::CountW-1:0]   cnt_q, cnt_d;
  logic                          pierce, leave;

  // Signed 12-bit views of voltage and thresholds
  logic signed [11:0] v_s, sp_s, on_s, off_s, delta;
  logic               go, delta_ge_kt, delta_gt_jump;

  assign v_s   = $signed({2'b00, item_i.voltage});
  assign sp_s  = $signed({2'b00, cfg_i.set_point});
  assign on_s  = $signed({4'b0000, cfg_i.on_hysteresis});
  assign off_s = $signed({4'b0000, cfg_i.off_hysteresis});
  assign delta = v_s - sp_s;

  // Next-state logic for one tick
  always_comb begin
    cutting_d = cutting_q;
    up_d      = up_q;
    down_d    = down_q;
    kerf_d    = kerf_q;
    run_d     = run_q;
    cnt_d     = cnt_q;
    pierce    = 1'b0;
    leave     = 1'b0;
    go        = 1'b0;
    stab_d    = (stab_q != thhc_pkg::TicksMax) ? stab_q + 1'b1 : stab_q;
    kt_d      = (kt_q != thhc_pkg::TicksMax) ? kt_q + 1'b1 : kt_q;

    // slope test (delta >= elapsed) and jump test, negative delta never fires
    delta_ge_kt   = !delta[11] && (thhc_pkg::TicksW'(delta[10:0]) >= kt_d);
    delta_gt_jump = !delta[11] && (delta[10:0] > {1'b0, cfg_i.kerf_jump_limit});

    // start of cutting
    if (!cutting_q && item_i.torch_on) begin
      cutting_d = 1'b1;
      up_d      = 1'b0;
      down_d    = 1'b0;
      kerf_d    = 1'b0;
      run_d     = 1'b0;
      stab_d    = '0;
    end

    if (cutting_d) begin
      if (item_i.arc_good && !prev_arc_q) begin
        pierce = 1'b1;
        cnt_d  = cnt_q + 1'b1;
      end
      if (!item_i.torch_on || !item_i.arc_good) begin
        up_d   = 1'b0;
        down_d = 1'b0;
        kerf_d = 1'b0;
        run_d  = 1'b0;
        if (!item_i.torch_on) begin
          cutting_d = 1'b0;
          leave     = 1'b1;
        end
      end else begin
        go = 1'b1;
        if (!run_d) begin
          if (kerf_d) begin
            if (v_s <= sp_s + (on_s <<< 1)) begin
              kerf_d = 1'b0;
              run_d  = 1'b1;
            end else begin
              go = 1'b0;
            end
          end else if (stab_d > cfg_i.stabilize_ms) begin
            run_d = 1'b1;
          end else begin
            go = 1'b0;
          end
        end

        // hysteresis regulation
        if (go) begin
          if (up_d) begin
            if (v_s >= sp_s - off_s) begin
              up_d = 1'b0; down_d = 1'b0; kerf_d = 1'b0; run_d = 1'b1;
            end
          end else if (v_s <= sp_s - on_s) begin
            up_d   = 1'b1;
            down_d = 1'b0;
          end else if (down_d) begin
            if (v_s <= sp_s + off_s) begin
              up_d = 1'b0; down_d = 1'b0; kerf_d = 1'b0; run_d = 1'b1;
            end else if (!kerf_d && (kt_d > KerfWait) && (delta_ge_kt || delta_gt_jump)) begin
              up_d = 1'b0; down_d = 1'b0; kerf_d = 1'b1; run_d = 1'b0;
            end
          end else if (v_s >= sp_s + on_s) begin
            up_d   = 1'b0;
            down_d = 1'b1;
            kt_d   = '0;
          end
        end
      end
    end
  end

  // State registers, updated once per transfer out of the input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cutting_q  <= 1'b0;
      prev_arc_q <= 1'b0;
      up_q       <= 1'b0;
      down_q     <= 1'b0;
      kerf_q     <= 1'b0;
      run_q      <= 1'b0;
      stab_q     <= '0;
      kt_q       <= '0;
      cnt_q      <= '0;
    end else if (adv_i) begin
      cutting_q  <= cutting_d;
      prev_arc_q <= item_i.arc_good;
      up_q       <= up_d;
      down_q     <= down_d;
      kerf_q     <= kerf_d;
      run_q      <= run_d;
      stab_q     <= stab_d;
      kt_q       <= kt_d;
      cnt_q      <= cnt_d;
    end
  end

  assign res_o.torch_up       = up_d;
  assign res_o.torch_down     = down_d;
  assign res_o.kerf_active    = kerf_d;
  assign res_o.control_active = run_d;
  assign res_o.pierce_done    = pierce;
  assign res_o.pierce_total   = cnt_d;
  assign res_o.leave_cutting  = leave;

endmodule

/* rtl/torch_height_hysteresis_control_top.sv */
// Top level: input register, control step, result register and configuration registers.
//
// Plasma torch height control. One tick item enters per clock cycle while input is not
// stalled: the item is captured in an input register, the control state is stepped by one
// tick as the item moves into the result register, and the result waits there until taken.
// Unstalled, the sustained rate is one item per cycle, as the state update is combinational;
// a stalled result stops input only once the input register is also full. The user must
// write configuration registers through cfg_we_i/cfg_idx_i/cfg_data_i while no item is in
// flight; the block itself leaves this to the user.
module torch_height_hysteresis_control_top #(
  parameter int unsigned KERF_WAIT_MS = thhc_pkg::KerfWaitDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  thhc_in_if.sink                       in_ch,
  thhc_out_if.source                    out_ch,
  input  logic                          cfg_we_i,
  input  logic [thhc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [thhc_pkg::CfgDatW-1:0]  cfg_data_i
);

  thhc_pkg::cfg_t    cfg;
  thhc_pkg::item_t   item_q;
  thhc_pkg::result_t res, res_q;
  logic              in_vld_q, out_vld_q, adv, in_take;

  // Advance when the input register holds an item and the result register is free or being emptied
  assign adv         = in_vld_q && (!out_vld_q || out_ch.ready);
  assign in_ch.ready = !in_vld_q || adv;
  assign in_take     = in_ch.valid && in_ch.ready;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_q <= in_ch.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.voltage  <= in_ch.voltage;
      item_q.torch_on <= in_ch.torch_on;
      item_q.arc_good <= in_ch.arc_good;
    end
  end

  thhc_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  thhc_step #(
    .KERF_WAIT_MS (KERF_WAIT_MS)
  ) u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (!out_vld_q || out_ch.ready) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res;
    end
  end

  assign out_ch.valid          = out_vld_q;
  assign out_ch.torch_up       = res_q.torch_up;
  assign out_ch.torch_down     = res_q.torch_down;
  assign out_ch.kerf_active    = res_q.kerf_active;
  assign out_ch.control_active = res_q.control_active;
  assign out_ch.pierce_done    = res_q.pierce_done;
  assign out_ch.pierce_total   = res_q.pierce_total;
  assign out_ch.leave_cutting  = res_q.leave_cutting;

endmodule

/* rtl/thhc_chk.sv */
// Checker: port-level properties of the torch height control, bound to the top level.
module thhc_chk (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         torch_up,
  input logic                         torch_down,
  input logic                         kerf_active,
  input logic                         control_active,
  input logic [thhc_pkg::CountW-1:0]  pierce_total,
  input logic                         leave_cutting
);

  // Drive directions are exclusive
  a_up_down_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !(torch_up && torch_down))
    else $error("torch up and down driven together");

  // A move only happens while control runs
  a_move_needs_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && (torch_up || torch_down) |-> control_active)
    else $error("torch move without active control");

  // A kerf suspends all drive and control
  a_kerf_suspends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && kerf_active |-> !torch_up && !torch_down && !control_active)
    else $error("drive active during kerf");

  // Leaving cutting clears every flag
  a_leave_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && leave_cutting |->
      !torch_up && !torch_down && !kerf_active && !control_active)
    else $error("flags left set on leaving cutting");

  // A stalled result stays valid and keeps its pierce total
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(pierce_total))
    else $error("stalled result changed");

endmodule

bind torch_height_hysteresis_control_top thhc_chk u_thhc_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .torch_up       (out_ch.torch_up),
  .torch_down     (out_ch.torch_down),
  .kerf_active    (out_ch.kerf_active),
  .control_active (out_ch.control_active),
  .pierce_total   (out_ch.pierce_total),
  .leave_cutting  (out_ch.leave_cutting)
);

/* verif/thhc_height_checker.sv */
// Checker: predicts each tick's torch height control result and compares it with the result channel.
module thhc_height_checker #(
  parameter int unsigned KerfWait = thhc_pkg::KerfWaitDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  thhc_in_if                           in_ch,
  thhc_out_if                          out_ch,
  input  logic                         cfg_we_i,
  input  logic [thhc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [thhc_pkg::CfgDatW-1:0] cfg_data_i,
  output int                           fail_count_o,
  output int                           pending_o
);
  import thhc_pkg::*;

  localparam int ReportMax = 10;

  // Mirror of the control registers and state
  cfg_t              cfg;
  logic              cutting, arc_q, moving_up, moving_down, in_kerf, regulating;
  logic [TicksW-1:0] settle_ticks, kerf_age;
  logic [CountW-1:0] pierces;

  result_t predicted_drive_q[$];
  result_t got, want;
  item_t   tick;
  int      results_seen;

  function automatic void set_flags(logic up, logic down, logic kerf, logic run);
    moving_up   = up;
    moving_down = down;
    in_kerf     = kerf;
    regulating  = run;
  endfunction

  // Hysteresis drive and kerf detection, once control runs
  function automatic void regulate(int v);
    int sp, on_h, off_h, jump, rise, age;
    sp    = cfg.set_point;
    on_h  = cfg.on_hysteresis;
    off_h = cfg.off_hysteresis;
    jump  = cfg.kerf_jump_limit;
    age   = kerf_age;
    if (moving_up) begin
      if (v >= sp - off_h) set_flags(1'b0, 1'b0, 1'b0, 1'b1);
    end else if (v <= sp - on_h) begin
      moving_up   = 1'b1;
      moving_down = 1'b0;
    end else if (moving_down) begin
      if (v <= sp + off_h) begin
        set_flags(1'b0, 1'b0, 1'b0, 1'b1);
      end else if (!in_kerf && kerf_age > KerfWait) begin
        rise = v - sp;
        // slope test in its exact form, or a plain jump over the limit
        if (rise >= age || rise > jump) set_flags(1'b0, 1'b0, 1'b1, 1'b0);
      end
    end else if (v >= sp + on_h) begin
      moving_up   = 1'b0;
      moving_down = 1'b1;
      kerf_age    = '0;
    end
  endfunction

  // One millisecond tick: returns the result and advances the state
  function automatic result_t height_ctrl_tick(item_t it);
    result_t r;
    int      v, sp, on_h;
    logic    rise, run_ok;
    r    = '0;
    v    = it.voltage;
    sp   = cfg.set_point;
    on_h = cfg.on_hysteresis;
    rise = it.arc_good && !arc_q;
    arc_q = it.arc_good;
    if (settle_ticks != TicksMax) settle_ticks++;
    if (kerf_age != TicksMax) kerf_age++;

    if (!cutting && it.torch_on) begin
      cutting = 1'b1;
      set_flags(1'b0, 1'b0, 1'b0, 1'b0);
      settle_ticks = '0;
    end

    if (cutting) begin
      if (rise) begin
        r.pierce_done = 1'b1;
        pierces++;
      end
      if (!it.torch_on) begin
        set_flags(1'b0, 1'b0, 1'b0, 1'b0);
        cutting         = 1'b0;
        r.leave_cutting = 1'b1;
      end else if (!it.arc_good) begin
        set_flags(1'b0, 1'b0, 1'b0, 1'b0);
      end else begin
        run_ok = 1'b1;
        if (!regulating) begin
          if (in_kerf) begin
            // kerf ends once the voltage is back near the set point
            if (v <= sp + 2 * on_h) begin
              in_kerf    = 1'b0;
              regulating = 1'b1;
            end else begin
              run_ok = 1'b0;
            end
          end else if (settle_ticks > cfg.stabilize_ms) begin
            regulating = 1'b1;
          end else begin
            run_ok = 1'b0;
          end
        end
        if (run_ok) regulate(v);
      end
    end

    r.torch_up       = moving_up;
    r.torch_down     = moving_down;
    r.kerf_active    = in_kerf;
    r.control_active = regulating;
    r.pierce_total   = pierces;
    return r;
  endfunction

  function automatic string fmt_drive(result_t r);
    return $sformatf("up=%b down=%b kerf=%b ctrl=%b pierce=%b total=%0d leave=%b",
                     r.torch_up, r.torch_down, r.kerf_active, r.control_active,
                     r.pierce_done, r.pierce_total, r.leave_cutting);
  endfunction

  task automatic report_miss(string what, result_t exp_r, result_t act_r);
    fail_count_o++;
    if (fail_count_o <= ReportMax) begin
      $display("[%0t] %s at result %0d", $realtime, what, results_seen);
      $display("  expected %s", fmt_drive(exp_r));
      $display("  actual   %s", fmt_drive(act_r));
    end
  endtask

  // Track config writes, check result transfers, predict on tick transfers
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg.set_point       = SetPointRst;
      cfg.on_hysteresis   = OnHystRst;
      cfg.off_hysteresis  = OffHystRst;
      cfg.stabilize_ms    = StabMsRst;
      cfg.kerf_jump_limit = JumpLimitRst;
      cutting      = 1'b0;
      arc_q        = 1'b0;
      set_flags(1'b0, 1'b0, 1'b0, 1'b0);
      settle_ticks = '0;
      kerf_age     = '0;
      pierces      = '0;
      predicted_drive_q.delete();
      results_seen = 0;
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegSetPoint:  cfg.set_point       = cfg_data_i[VoltW-1:0];
          RegOnHyst:    cfg.on_hysteresis   = cfg_data_i[HystW-1:0];
          RegOffHyst:   cfg.off_hysteresis  = cfg_data_i[HystW-1:0];
          RegStabMs:    cfg.stabilize_ms    = cfg_data_i[TicksW-1:0];
          RegJumpLimit: cfg.kerf_jump_limit = cfg_data_i[VoltW-1:0];
          default: ;
        endcase
      end

      if (out_ch.valid && out_ch.ready) begin
        got.torch_up       = out_ch.torch_up;
        got.torch_down     = out_ch.torch_down;
        got.kerf_active    = out_ch.kerf_active;
        got.control_active = out_ch.control_active;
        got.pierce_done    = out_ch.pierce_done;
        got.pierce_total   = out_ch.pierce_total;
        got.leave_cutting  = out_ch.leave_cutting;
        results_seen++;
        if (predicted_drive_q.size() == 0) begin
          report_miss("unexpected result", '0, got);
        end else begin
          want = predicted_drive_q.pop_front();
          if (got !== want) report_miss("result mismatch", want, got);
        end
      end

      if (in_ch.valid && in_ch.ready) begin
        tick.voltage  = in_ch.voltage;
        tick.torch_on = in_ch.torch_on;
        tick.arc_good = in_ch.arc_good;
        predicted_drive_q.push_back(height_ctrl_tick(tick));
      end

      pending_o = predicted_drive_q.size();
    end
  end

endmodule

/* verif/torch_height_hysteresis_control_top_tb.sv */
// Testbench top: clock, reset, tick stimulus, config phases, result stalls and verdict.
module torch_height_hysteresis_control_top_tb;
  import thhc_pkg::*;

  localparam int QuietLimit    = 2000;
  localparam int ItemsPerPhase = 225;
  localparam int VoltMax       = 2 ** VoltW - 1;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [CfgDatW-1:0] cfg_data;
  int                 fail_count, pending;
  int                 idle_pct, stall_pct;
  int                 sp_cur, on_cur, jump_cur;
  int                 sent, quiet;

  thhc_in_if  tick_ch();
  thhc_out_if drive_ch();

  torch_height_hysteresis_control_top i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_ch      (tick_ch),
    .out_ch     (drive_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  thhc_height_checker i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_ch        (tick_ch),
    .out_ch       (drive_ch),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side stalls at random
  always @(negedge clk) begin
    drive_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if ((tick_ch.valid && tick_ch.ready) || (drive_ch.valid && drive_ch.ready)) begin
        quiet <= 0;
      end else if (quiet >= QuietLimit) begin
        $display("FAIL");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  // One tick transfer, with random idle cycles ahead of it
  task automatic send_tick(int v, logic torch, logic arc);
    while ($urandom_range(99) < idle_pct) begin
      tick_ch.valid <= 1'b0;
      @(negedge clk);
    end
    tick_ch.valid    <= 1'b1;
    tick_ch.voltage  <= v[VoltW-1:0];
    tick_ch.torch_on <= torch;
    tick_ch.arc_good <= arc;
    do @(posedge clk); while (!tick_ch.ready);
    sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, int data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data[CfgDatW-1:0];
    @(negedge clk);
  endtask

  task automatic set_config(int sp, int on_h, int off_h, int stab, int jump);
    write_reg(RegSetPoint, sp);
    write_reg(RegOnHyst, on_h);
    write_reg(RegOffHyst, off_h);
    write_reg(RegStabMs, stab);
    write_reg(RegJumpLimit, jump);
    cfg_we   <= 1'b0;
    sp_cur   = sp;
    on_cur   = on_h;
    jump_cur = jump;
  endtask

  // Drain: every predicted result has come back, then a few spare cycles
  task automatic wait_idle();
    tick_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // One cut: torch on, arc comes up, voltage wanders around the set point, torch off
  task automatic run_cut();
    int   v, mode, seg, len;
    logic arc;
    repeat ($urandom_range(2)) send_tick($urandom_range(VoltMax), 1'b0, $urandom_range(1) == 1);
    repeat ($urandom_range(3)) send_tick($urandom_range(VoltMax), 1'b1, 1'b0);
    v    = sp_cur;
    seg  = 0;
    mode = 0;
    len  = $urandom_range(20, 90);
    for (int k = 0; k < len; k++) begin
      if (seg == 0) begin
        mode = $urandom_range(4);
        seg  = $urandom_range(4, 20);
      end
      seg--;
      case (mode)
        0:       v = sp_cur + int'($urandom_range(2 * (on_cur + 3))) - (on_cur + 3);
        1:       v = v + int'($urandom_range(3));     // ramp up, slope test
        2:       v = v - int'($urandom_range(3));     // ramp down, kerf release
        3:       v = sp_cur + jump_cur + int'($urandom_range(8)) - 4;
        default: v = sp_cur + on_cur + int'($urandom_range(4));  // hold a down move
      endcase
      if (v < 0) v = 0;
      if (v > VoltMax) v = VoltMax;
      arc = ($urandom_range(39) != 0);
      send_tick(v, 1'b1, arc);
    end
    send_tick(v, 1'b0, $urandom_range(1) == 1);
  endtask

  initial begin
    int limit, on_h;
    rst_n            = 1'b0;
    tick_ch.valid    = 1'b0;
    tick_ch.voltage  = '0;
    tick_ch.torch_on = 1'b0;
    tick_ch.arc_good = 1'b0;
    drive_ch.ready   = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = RegSetPoint;
    cfg_data         = '0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: idle, start, arc loss, pierce, up, at height, down, kerf jump, release, off
    set_config(512, 7, 3, 2, 21);
    send_tick(0, 1'b0, 1'b0);
    send_tick(1023, 1'b0, 1'b1);
    send_tick(512, 1'b1, 1'b1);
    send_tick(512, 1'b1, 1'b0);
    send_tick(512, 1'b1, 1'b1);
    send_tick(512, 1'b1, 1'b1);
    send_tick(0, 1'b1, 1'b1);
    send_tick(510, 1'b1, 1'b1);
    send_tick(520, 1'b1, 1'b1);
    repeat (12) send_tick(520, 1'b1, 1'b1);
    send_tick(540, 1'b1, 1'b1);
    send_tick(530, 1'b1, 1'b1);
    send_tick(520, 1'b1, 1'b1);
    send_tick(520, 1'b0, 1'b0);

    // Random phases, each with its own settings and one of four idle and stall patterns
    for (int p = 0; p < 6; p++) begin
      wait_idle();
      case (p)
        0: set_config(512, 7, 3, 5, 21);
        1: set_config(0, 0, 0, 0, 0);
        2: set_config(VoltMax, 255, 255, 65535, VoltMax);
        4: set_config($urandom_range(VoltMax), $urandom_range(255), $urandom_range(255),
                      $urandom_range(40), $urandom_range(VoltMax));
        default: begin
          on_h = $urandom_range(2, 30);
          set_config($urandom_range(200, 800), on_h, $urandom_range(on_h),
                     $urandom_range(25), $urandom_range(60));
        end
      endcase
      case (p % 4)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 48; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 48; end
        default: begin idle_pct = 23; stall_pct = 23; end
      endcase
      limit = sent + ItemsPerPhase;
      while (sent < limit) begin
        if ($urandom_range(9) == 0) begin
          repeat ($urandom_range(1, 10))
            send_tick($urandom_range(VoltMax), $urandom_range(1) == 1, $urandom_range(1) == 1);
        end else begin
          run_cut();
        end
      end
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
